[design/lbt_pkg.sv]
package lbt_pkg;

    localparam int TABLES           = 4;
    localparam int DIGITS_PER_TABLE = 4;
    localparam int BIN_BITS         = 2;
    localparam int BUCKET_DEPTH     = 16;

    localparam int HASH_W      = 2;
    localparam int HASH_PORTS  = 4;
    localparam int SEL_W       = 2;
    localparam int ID_W        = 31;
    localparam int BIDX_OUT_W  = 8;

    localparam int IDX_W       = DIGITS_PER_TABLE * BIN_BITS;
    localparam int TSEL_W      = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int BKT_W       = TSEL_W + IDX_W;
    localparam int META_DEPTH  = TABLES * (1 << IDX_W);
    localparam int SLOT_W      = $clog2(BUCKET_DEPTH);
    localparam int CNT_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int ENT_AW      = BKT_W + SLOT_W;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_QUERY  = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] wp;
    } meta_t;

    typedef struct packed {
        logic             en;
        logic [BKT_W-1:0] addr;
        meta_t            data;
    } meta_wr_t;

    function automatic logic [IDX_W-1:0] make_index(
        input logic [HASH_PORTS-1:0][HASH_W-1:0] digits
    );
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < DIGITS_PER_TABLE; j++) begin
            idx = idx | (IDX_W'(BIN_BITS'(digits[j])) << ((DIGITS_PER_TABLE - 1 - j) * BIN_BITS));
        end
        return idx;
    endfunction

    function automatic logic [TSEL_W-1:0] wrap_table(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] v;
        v = sel;
        for (int i = 0; i < (1 << SEL_W) - 1; i++) begin
            if (int'(v) >= TABLES) begin
                v = v - SEL_W'(TABLES);
            end
        end
        return TSEL_W'(v);
    endfunction

endpackage

[design/lbt_meta.sv]
module lbt_meta (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear_start,
    input  logic                          rd_en,
    input  logic [lbt_pkg::BKT_W-1:0]     rd_addr,
    output lbt_pkg::meta_t                rd_data,
    input  lbt_pkg::meta_wr_t             wr,
    output logic                          busy
);

    lbt_pkg::meta_t               mem [0:lbt_pkg::META_DEPTH-1];
    logic [lbt_pkg::BKT_W-1:0]    sweep_reg;
    logic                         busy_reg;
    lbt_pkg::meta_t               rd_data_reg;

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

    // sweep every bucket to zero after reset and on clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end else if (clear_start) begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end else if (busy_reg) begin
            sweep_reg <= sweep_reg + 1'b1;
            if (sweep_reg == lbt_pkg::BKT_W'(lbt_pkg::META_DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[sweep_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[design/lsh_bucket_table_top.sv]
// Multi-table LSH bucket store. Each input word selects a table and carries its hash
// digits; the digits form the bucket index. Insert (func 0) stores item_id in the
// bucket's ring: one read of the bucket's pointer memory, then the write of entry and
// pointer. Query (func 1) streams the bucket's ids (up to 16) in slot order, or one
// word with empty_res set for an empty bucket; last marks the final word. Entry reads
// come from a single-port-read entry memory at one id per cycle when m_ready stays high.
// Clear (func 2) and reset zero all pointers and full flags in a sweep of the whole
// pointer memory (1024 entries), during which s_ready stays low. Stored ids are not
// cleared. func 3 is accepted and dropped.
module lsh_bucket_table_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_func,
    input  logic [lbt_pkg::SEL_W-1:0]       s_table_sel,
    input  logic [lbt_pkg::HASH_W-1:0]      s_hash_0,
    input  logic [lbt_pkg::HASH_W-1:0]      s_hash_1,
    input  logic [lbt_pkg::HASH_W-1:0]      s_hash_2,
    input  logic [lbt_pkg::HASH_W-1:0]      s_hash_3,
    input  logic [lbt_pkg::ID_W-1:0]        s_item_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lbt_pkg::ID_W-1:0]        m_found_id,
    output logic [lbt_pkg::BIDX_OUT_W-1:0]  m_bucket_index,
    output logic                            m_empty_res,
    output logic                            m_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_QUERY
    } state_t;

    state_t                                        state_reg;
    logic                                          is_insert_reg;
    logic [lbt_pkg::BKT_W-1:0]                     bkt_reg;
    logic [lbt_pkg::BIDX_OUT_W-1:0]                bidx_reg;
    logic [lbt_pkg::ID_W-1:0]                      id_reg;
    logic [lbt_pkg::CNT_W-1:0]                     n_reg;
    logic [lbt_pkg::CNT_W-1:0]                     k_reg;
    logic                                          rd_pend_reg;
    logic                                          m_valid_reg;
    logic [lbt_pkg::ID_W-1:0]                      m_found_id_reg;
    logic [lbt_pkg::BIDX_OUT_W-1:0]                m_bucket_index_reg;
    logic                                          m_empty_res_reg;
    logic                                          m_last_reg;

    logic [lbt_pkg::ID_W-1:0]                      ent_mem [0:(1 << lbt_pkg::ENT_AW)-1];
    logic [lbt_pkg::ID_W-1:0]                      ent_rd_data_reg;

    logic [lbt_pkg::HASH_PORTS-1:0][lbt_pkg::HASH_W-1:0] hash_vec;
    logic [lbt_pkg::IDX_W-1:0]                     in_idx;
    logic [lbt_pkg::BKT_W-1:0]                     in_bkt;
    logic                                          acc;
    logic                                          meta_rd_en;
    logic                                          meta_clear;
    logic                                          meta_busy;
    lbt_pkg::meta_t                                meta_rd;
    lbt_pkg::meta_wr_t                             meta_wr;
    logic                                          wrap;
    logic                                          ent_wr_en;
    logic [lbt_pkg::ENT_AW-1:0]                    ent_wr_addr;
    logic                                          ent_rd_en;
    logic [lbt_pkg::ENT_AW-1:0]                    ent_rd_addr;
    logic                                          m_free;
    logic                                          load;

    assign hash_vec = {s_hash_3, s_hash_2, s_hash_1, s_hash_0};

    always_comb begin
        in_idx     = lbt_pkg::make_index(hash_vec);
        in_bkt     = {lbt_pkg::wrap_table(s_table_sel), in_idx};
        s_ready    = (state_reg == S_IDLE) && !meta_busy;
        acc        = s_valid && s_ready;
        meta_rd_en = acc && (s_func == lbt_pkg::FN_INSERT || s_func == lbt_pkg::FN_QUERY);
        meta_clear = acc && (s_func == lbt_pkg::FN_CLEAR);

        wrap         = (meta_rd.wp == lbt_pkg::SLOT_W'(lbt_pkg::BUCKET_DEPTH - 1));
        ent_wr_en    = (state_reg == S_META) && is_insert_reg;
        ent_wr_addr  = {bkt_reg, meta_rd.wp};
        meta_wr.en   = ent_wr_en;
        meta_wr.addr = bkt_reg;
        meta_wr.data.full = meta_rd.full || wrap;
        meta_wr.data.wp   = wrap ? '0 : meta_rd.wp + 1'b1;

        m_free      = !m_valid_reg || m_ready;
        load        = rd_pend_reg && m_free;
        ent_rd_en   = (state_reg == S_QUERY) && (k_reg != n_reg) && (!rd_pend_reg || load);
        ent_rd_addr = {bkt_reg, k_reg[lbt_pkg::SLOT_W-1:0]};
    end

    lbt_meta u_meta (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear_start (meta_clear),
        .rd_en       (meta_rd_en),
        .rd_addr     (in_bkt),
        .rd_data     (meta_rd),
        .wr          (meta_wr),
        .busy        (meta_busy)
    );

    always_ff @(posedge aclk) begin
        if (ent_wr_en) begin
            ent_mem[ent_wr_addr] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_rd_en) begin
            ent_rd_data_reg <= ent_mem[ent_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        is_insert_reg <= (s_func == lbt_pkg::FN_INSERT);
                        bkt_reg       <= in_bkt;
                        bidx_reg      <= lbt_pkg::BIDX_OUT_W'(in_idx);
                        id_reg        <= s_item_id;
                        if (meta_rd_en) begin
                            state_reg <= S_META;
                        end
                    end
                end
                S_META: begin
                    if (is_insert_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        n_reg     <= meta_rd.full ? lbt_pkg::CNT_W'(lbt_pkg::BUCKET_DEPTH)
                                                  : lbt_pkg::CNT_W'(meta_rd.wp);
                        k_reg     <= '0;
                        state_reg <= S_QUERY;
                    end
                end
                S_QUERY: begin
                    if (n_reg == '0) begin
                        if (m_free) begin
                            m_valid_reg        <= 1'b1;
                            m_found_id_reg     <= '0;
                            m_bucket_index_reg <= bidx_reg;
                            m_empty_res_reg    <= 1'b1;
                            m_last_reg         <= 1'b1;
                            state_reg          <= S_IDLE;
                        end
                    end else begin
                        if (ent_rd_en) begin
                            k_reg       <= k_reg + 1'b1;
                            rd_pend_reg <= 1'b1;
                        end else if (load) begin
                            rd_pend_reg <= 1'b0;
                        end
                        if (load) begin
                            m_valid_reg        <= 1'b1;
                            m_found_id_reg     <= ent_rd_data_reg;
                            m_bucket_index_reg <= bidx_reg;
                            m_empty_res_reg    <= 1'b0;
                            m_last_reg         <= (k_reg == n_reg);
                            if (k_reg == n_reg) begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found_id     = m_found_id_reg;
    assign m_bucket_index = m_bucket_index_reg;
    assign m_empty_res    = m_empty_res_reg;
    assign m_last         = m_last_reg;

endmodule

[design/lbt_checker.sv]
module lbt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [1:0]                      s_func,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lbt_pkg::ID_W-1:0]        m_found_id,
    input logic [lbt_pkg::BIDX_OUT_W-1:0]  m_bucket_index,
    input logic                            m_empty_res,
    input logic                            m_last
);

    // empty marker is a one-word run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last)
        else $error("empty word without last");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_found_id == '0)
        else $error("empty word carries an id");

    // one item at a time: a working word drops ready
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == lbt_pkg::FN_INSERT || s_func == lbt_pkg::FN_QUERY
            || s_func == lbt_pkg::FN_CLEAR) |=> !s_ready)
        else $error("ready held after accepting a word");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_id) && $stable(m_bucket_index)
            && $stable(m_empty_res) && $stable(m_last))
        else $error("result word changed while stalled");

endmodule

bind lsh_bucket_table_top lbt_checker u_lbt_checker (.*);

[dv/tb_lsh_bucket_table_top.sv]
`timescale 1ns / 1ps

class lsh_bucket_mirror;
    typedef struct {
        logic [lbt_pkg::ID_W-1:0]       found_id;
        logic [lbt_pkg::BIDX_OUT_W-1:0] bucket_index;
        logic                           empty_res;
        logic                           last;
    } hit_t;

    logic [lbt_pkg::ID_W-1:0] slot_ids [lbt_pkg::META_DEPTH*lbt_pkg::BUCKET_DEPTH];
    int unsigned     fill_ptr [lbt_pkg::META_DEPTH];
    bit              wrapped [lbt_pkg::META_DEPTH];
    hit_t            pending_hits[$];
    int unsigned     mismatches;
    int unsigned     words_checked;
    int unsigned     inserts;
    int unsigned     queries;
    int unsigned     full_queries;
    int unsigned     clears;

    function new();
        clear_meta();
    endfunction

    function void clear_meta();
        for (int k = 0; k < lbt_pkg::META_DEPTH; k++) begin
            fill_ptr[k] = 0;
            wrapped[k]  = 1'b0;
        end
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", what);
        end
    endfunction

    function void note_word(logic [1:0] func, logic [lbt_pkg::SEL_W-1:0] tsel,
                            logic [lbt_pkg::HASH_PORTS-1:0][lbt_pkg::HASH_W-1:0] digits,
                            logic [lbt_pkg::ID_W-1:0] id);
        int unsigned idx;
        int unsigned bkt;
        int unsigned n;
        hit_t        h;
        idx = 0;
        for (int j = 0; j < lbt_pkg::DIGITS_PER_TABLE; j++) begin
            idx |= (int'(digits[j]) & ((1 << lbt_pkg::BIN_BITS) - 1))
                   << ((lbt_pkg::DIGITS_PER_TABLE - 1 - j) * lbt_pkg::BIN_BITS);
        end
        idx &= (1 << lbt_pkg::IDX_W) - 1;
        bkt = (int'(tsel) % lbt_pkg::TABLES) * (1 << lbt_pkg::IDX_W) + idx;
        h.bucket_index = lbt_pkg::BIDX_OUT_W'(idx);
        case (func)
            lbt_pkg::FN_INSERT: begin
                inserts++;
                slot_ids[bkt*lbt_pkg::BUCKET_DEPTH + fill_ptr[bkt]] = id;
                fill_ptr[bkt]++;
                if (fill_ptr[bkt] == lbt_pkg::BUCKET_DEPTH) begin
                    fill_ptr[bkt] = 0;
                    wrapped[bkt]  = 1'b1;
                end
            end
            lbt_pkg::FN_QUERY: begin
                queries++;
                if (wrapped[bkt]) begin
                    full_queries++;
                end
                n = wrapped[bkt] ? lbt_pkg::BUCKET_DEPTH : fill_ptr[bkt];
                if (n == 0) begin
                    h.found_id  = '0;
                    h.empty_res = 1'b1;
                    h.last      = 1'b1;
                    pending_hits.push_back(h);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        h.found_id  = slot_ids[bkt*lbt_pkg::BUCKET_DEPTH + k];
                        h.empty_res = 1'b0;
                        h.last      = (k == n - 1);
                        pending_hits.push_back(h);
                    end
                end
            end
            lbt_pkg::FN_CLEAR: begin
                clears++;
                clear_meta();
            end
            default: ;
        endcase
    endfunction

    function void check_word(logic [lbt_pkg::ID_W-1:0] found_id,
                             logic [lbt_pkg::BIDX_OUT_W-1:0] bucket_index,
                             logic empty_res, logic last);
        hit_t want;
        if (pending_hits.size() == 0) begin
            flag($sformatf("unexpected word: id %h idx %h empty %b last %b",
                           found_id, bucket_index, empty_res, last));
            return;
        end
        want = pending_hits.pop_front();
        words_checked++;
        if (want.found_id !== found_id || want.bucket_index !== bucket_index ||
            want.empty_res !== empty_res || want.last !== last) begin
            flag($sformatf({"mismatch: expected id %h idx %h empty %b last %b,",
                            " got id %h idx %h empty %b last %b"},
                           want.found_id, want.bucket_index, want.empty_res, want.last,
                           found_id, bucket_index, empty_res, last));
        end
    endfunction

    function void drain_check();
        hit_t want;
        while (pending_hits.size() != 0) begin
            want = pending_hits.pop_front();
            flag($sformatf("missing word: id %h idx %h empty %b last %b",
                           want.found_id, want.bucket_index, want.empty_res, want.last));
        end
    endfunction
endclass

module tb_lsh_bucket_table_top;
    localparam int         ITEMS          = 150;
    localparam int         STALL_MAX      = 17;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 64;
    localparam logic [1:0] FN_SPARE       = 2'd3;
    localparam int         KEY_W          = lbt_pkg::SEL_W
                                            + lbt_pkg::HASH_PORTS*lbt_pkg::HASH_W;

    typedef struct packed {
        logic [lbt_pkg::SEL_W-1:0]                           tsel;
        logic [lbt_pkg::HASH_PORTS-1:0][lbt_pkg::HASH_W-1:0] digits;
    } bucket_key_t;

    logic                           aclk           = 1'b0;
    logic                           aresetn        = 1'b0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_func         = '0;
    logic [lbt_pkg::SEL_W-1:0]      s_table_sel    = '0;
    logic [lbt_pkg::HASH_W-1:0]     s_hash_0       = '0;
    logic [lbt_pkg::HASH_W-1:0]     s_hash_1       = '0;
    logic [lbt_pkg::HASH_W-1:0]     s_hash_2       = '0;
    logic [lbt_pkg::HASH_W-1:0]     s_hash_3       = '0;
    logic [lbt_pkg::ID_W-1:0]       s_item_id      = '0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [lbt_pkg::ID_W-1:0]       m_found_id;
    logic [lbt_pkg::BIDX_OUT_W-1:0] m_bucket_index;
    logic                           m_empty_res;
    logic                           m_last;

    lsh_bucket_mirror mirror = new();
    int unsigned      words_sent = 0;
    bit               send_burst = 1'b0;
    bit               recv_burst = 1'b0;
    bucket_key_t      hot_keys [3];

    always #4 aclk = ~aclk;

    lsh_bucket_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_table_sel   (s_table_sel),
        .s_hash_0      (s_hash_0),
        .s_hash_1      (s_hash_1),
        .s_hash_2      (s_hash_2),
        .s_hash_3      (s_hash_3),
        .s_item_id     (s_item_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found_id    (m_found_id),
        .m_bucket_index(m_bucket_index),
        .m_empty_res   (m_empty_res),
        .m_last        (m_last)
    );

    function automatic int unsigned draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    task automatic send_word(input logic [1:0] func, input bucket_key_t key,
                             input logic [lbt_pkg::ID_W-1:0] id);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if ($urandom_range(0, 19) == 0) begin
            send_burst = !send_burst;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_table_sel <= key.tsel;
        s_hash_0    <= key.digits[0];
        s_hash_1    <= key.digits[1];
        s_hash_2    <= key.digits[2];
        s_hash_3    <= key.digits[3];
        s_item_id   <= id;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (func != FN_SPARE) begin
            words_sent++;
        end
        mirror.note_word(func, key.tsel, key.digits, id);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.pending_hits.size() != 0);
    endtask

    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = draw_gap(recv_burst);
            if ($urandom_range(0, 19) == 0) begin
                recv_burst = !recv_burst;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1 || aresetn !== 1'b1);
            mirror.check_word(m_found_id, m_bucket_index, m_empty_res, m_last);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_lsh_bucket_table_top: errors");
        $finish;
    end

    initial begin : stimulus
        bucket_key_t key;
        bucket_key_t k_lo;
        bucket_key_t k_hi;
        bucket_key_t k_mix;
        bucket_key_t k_alt;
        int unsigned n;
        int unsigned pick;
        bit          paused;
        k_lo   = '{tsel: '0, digits: '0};
        k_hi   = '{tsel: '1, digits: '1};
        k_mix  = '{tsel: 2'd1, digits: {2'd0, 2'd3, 2'd2, 2'd1}};
        k_alt  = '{tsel: 2'd2, digits: {2'd0, 2'd3, 2'd2, 2'd1}};
        paused = 1'b0;
        for (int i = 0; i < 3; i++) begin
            hot_keys[i] = KEY_W'($urandom());
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(lbt_pkg::FN_QUERY, k_lo, '0);
        send_word(lbt_pkg::FN_QUERY, k_hi, '1);
        send_word(lbt_pkg::FN_INSERT, k_lo, '0);
        send_word(lbt_pkg::FN_INSERT, k_lo, '1);
        send_word(lbt_pkg::FN_INSERT, k_hi, 31'h2AAA_AAAA);
        send_word(lbt_pkg::FN_INSERT, k_hi, 31'h5555_5555);
        send_word(lbt_pkg::FN_QUERY, k_lo, '0);
        send_word(lbt_pkg::FN_QUERY, k_hi, '0);
        send_word(lbt_pkg::FN_INSERT, k_mix, lbt_pkg::ID_W'($urandom()));
        send_word(lbt_pkg::FN_QUERY, k_mix, '0);
        send_word(lbt_pkg::FN_QUERY, k_alt, '0);
        send_word(FN_SPARE, k_hi, '1);
        send_word(lbt_pkg::FN_QUERY, k_lo, '0);
        send_word(lbt_pkg::FN_CLEAR, k_lo, '0);
        send_word(lbt_pkg::FN_QUERY, k_lo, '0);
        send_word(lbt_pkg::FN_QUERY, k_hi, '0);
        send_word(lbt_pkg::FN_INSERT, k_lo, 31'd1);
        send_word(lbt_pkg::FN_QUERY, k_lo, '0);
        wait_drained();

        // fill one bucket exactly to the wrap, then past it
        repeat (lbt_pkg::BUCKET_DEPTH) begin
            send_word(lbt_pkg::FN_INSERT, hot_keys[0], lbt_pkg::ID_W'($urandom()));
        end
        send_word(lbt_pkg::FN_QUERY, hot_keys[0], lbt_pkg::ID_W'($urandom()));
        repeat (2) send_word(lbt_pkg::FN_INSERT, hot_keys[0], lbt_pkg::ID_W'($urandom()));
        send_word(lbt_pkg::FN_QUERY, hot_keys[0], lbt_pkg::ID_W'($urandom()));

        while (words_sent < ITEMS) begin
            if (!paused && words_sent >= ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0) begin
                key = hot_keys[$urandom_range(0, 2)];
            end else begin
                key = KEY_W'($urandom());
            end
            if (pick < 65) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 5);
                repeat (n) send_word(lbt_pkg::FN_INSERT, key, lbt_pkg::ID_W'($urandom()));
                send_word(lbt_pkg::FN_QUERY, key, lbt_pkg::ID_W'($urandom()));
            end else if (pick < 85) begin
                send_word(lbt_pkg::FN_QUERY, key, lbt_pkg::ID_W'($urandom()));
            end else if (pick < 91) begin
                send_word(FN_SPARE, KEY_W'($urandom()), lbt_pkg::ID_W'($urandom()));
            end else if (pick < 94) begin
                send_word(lbt_pkg::FN_CLEAR, KEY_W'($urandom()), lbt_pkg::ID_W'($urandom()));
            end else begin
                send_word(lbt_pkg::FN_INSERT, KEY_W'($urandom()),
                          lbt_pkg::ID_W'($urandom()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mirror.drain_check();
        $display("summary: %0d inserts, %0d queries (%0d on full buckets), %0d clears",
                 mirror.inserts, mirror.queries, mirror.full_queries, mirror.clears);
        $display("summary: %0d result words checked, %0d failures",
                 mirror.words_checked, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("tb_lsh_bucket_table_top: clean");
        end else begin
            $display("tb_lsh_bucket_table_top: errors");
        end
        $finish;
    end
endmodule

[files.f]
design/lbt_pkg.sv
design/lbt_meta.sv
design/lsh_bucket_table_top.sv
design/lbt_checker.sv
dv/tb_lsh_bucket_table_top.sv
